// ----- sv/mpfb_pkg.sv -----
// Shared types and constants of the monochrome page framebuffer.
`default_nettype none
package mpfb_pkg;

  // Command opcodes at the input port.
  localparam logic [2:0] OP_SET_PIXEL = 3'd0;
  localparam logic [2:0] OP_CLR_PIXEL = 3'd1;
  localparam logic [2:0] OP_OR_COLUMN = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [2:0] OP_READ_BYTE = 3'd4;

  // Byte address width for the largest supported store (256 columns x 8 pages).
  localparam int ADDR_W = 11;

  // Command queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    K_NOP,
    K_SET,
    K_CLR,
    K_CLEAR_ALL,
    K_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic                en0;
    logic [ADDR_W-1:0]   addr0;
    logic [7:0]          mask0;
    logic                en1;
    logic [ADDR_W-1:0]   addr1;
    logic [7:0]          mask1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_ctl_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_MOD0,
    BS_FETCH1,
    BS_MOD1
  } back_state_t;

endpackage
`default_nettype wire

// ----- sv/mpfb_front.sv -----
// Command front end: accept handshake and decode into store byte operations.
`default_nettype none
module mpfb_front
  import mpfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 4
) (
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_opcode,
  input  wire logic [7:0] in_x_column,
  input  wire logic [7:0] in_y_row,
  input  wire logic [7:0] in_pattern,
  input  wire logic [3:0] in_row_count,
  input  wire logic [8:0] in_read_index,
  input  wire q_status_t  q_stat,
  input  wire back_ctl_t  back_ctl,
  output logic            push,
  output entry_t          push_entry
);

  localparam int ROWS  = PAGES * 8;
  localparam int STORE = COLUMNS * PAGES;

  logic        x_ok;
  logic [3:0]  draw_cnt;
  logic [8:0]  low_mask;
  logic [7:0]  col_bits;
  logic [15:0] col_ext;
  logic [4:0]  pg0;
  logic [4:0]  pg1;

  assign busy = q_stat.full | back_ctl.init_busy;
  assign push = start & ~busy;

  assign x_ok     = 32'(in_x_column) < COLUMNS;
  assign draw_cnt = (in_row_count > 4'd8) ? 4'd8 : in_row_count;
  assign low_mask = (9'd1 << draw_cnt) - 9'd1;
  assign col_bits = in_pattern & low_mask[7:0];
  assign col_ext  = {8'h00, col_bits} << in_y_row[2:0];
  assign pg0      = in_y_row[7:3];
  assign pg1      = pg0 + 5'd1;

  always_comb begin
    push_entry       = '0;
    push_entry.kind  = K_NOP;
    push_entry.addr0 = ADDR_W'(32'(in_x_column) + 32'(pg0) * COLUMNS);
    push_entry.addr1 = ADDR_W'(32'(in_x_column) + 32'(pg1) * COLUMNS);
    unique case (in_opcode)
      OP_SET_PIXEL, OP_CLR_PIXEL: begin
        push_entry.kind  = (in_opcode == OP_SET_PIXEL) ? K_SET : K_CLR;
        push_entry.en0   = x_ok && (32'(in_y_row) < ROWS);
        push_entry.mask0 = 8'd1 << in_y_row[2:0];
      end
      OP_OR_COLUMN: begin
        push_entry.kind  = K_SET;
        push_entry.mask0 = col_ext[7:0];
        push_entry.mask1 = col_ext[15:8];
        push_entry.en0   = x_ok && (32'(pg0) < PAGES) && (col_ext[7:0] != 8'h00);
        push_entry.en1   = x_ok && (32'(pg1) < PAGES) && (col_ext[15:8] != 8'h00);
      end
      OP_CLEAR_ALL: begin
        push_entry.kind = K_CLEAR_ALL;
      end
      OP_READ_BYTE: begin
        push_entry.kind  = K_READ;
        push_entry.en0   = 32'(in_read_index) < STORE;
        push_entry.addr0 = ADDR_W'(in_read_index);
      end
      default: begin
        push_entry.kind = K_NOP;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/mpfb_queue.sv -----
// Short command queue between the decode front end and the store sequencer.
`default_nettype none
module mpfb_queue
  import mpfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire entry_t    push_entry,
  input  wire back_ctl_t back_ctl,
  output q_status_t      q_stat,
  output entry_t         head
);

  entry_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign q_stat.full  = cnt_r == QCNT_W'(QDEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign head         = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = back_ctl.pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(back_ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ----- sv/mpfb_back.sv -----
// Store sequencer: pixel memory, read-modify-write, clear sweep and result strobe.
`default_nettype none
module mpfb_back
  import mpfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_stat,
  input  wire entry_t    head,
  output back_ctl_t      back_ctl,
  output logic           out_valid,
  output logic [7:0]     out_read_data
);

  localparam int STORE = COLUMNS * PAGES;
  localparam int AW    = $clog2(STORE);

  logic [7:0]    mem [STORE];
  logic [7:0]    rdata_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic [AW-1:0] ra;

  back_state_t   state_r;
  back_state_t   state_nxt;
  entry_t        cur_r;
  entry_t        cur_nxt;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] cnt_nxt;
  logic          report_r;
  logic          report_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [7:0]    out_data_r;
  logic [7:0]    out_data_nxt;

  function automatic logic [7:0] modify(op_kind_t k, logic [7:0] d, logic [7:0] m);
    return (k == K_CLR) ? (d & ~m) : (d | m);
  endfunction

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    report_nxt    = report_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    we            = 1'b0;
    wa            = cur_r.addr0[AW-1:0];
    wd            = '0;
    ra            = cur_r.addr0[AW-1:0];
    back_ctl.pop       = 1'b0;
    back_ctl.init_busy = (state_r == BS_CLEAR) && !report_r;
    unique case (state_r)
      BS_CLEAR: begin
        we      = 1'b1;
        wa      = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AW'(STORE - 1)) begin
          state_nxt     = BS_IDLE;
          out_valid_nxt = report_r;
          report_nxt    = 1'b0;
        end
      end
      BS_IDLE: begin
        ra = head.addr0[AW-1:0];
        if (!q_stat.empty) begin
          back_ctl.pop = 1'b1;
          cur_nxt      = head;
          unique case (head.kind)
            K_READ: begin
              if (head.en0) begin
                state_nxt = BS_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            K_SET, K_CLR: begin
              priority if (head.en0) begin
                state_nxt = BS_MOD0;
              end else if (head.en1) begin
                state_nxt = BS_FETCH1;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            K_CLEAR_ALL: begin
              state_nxt  = BS_CLEAR;
              cnt_nxt    = '0;
              report_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      BS_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rdata_r;
        state_nxt     = BS_IDLE;
      end
      BS_MOD0: begin
        we = 1'b1;
        wd = modify(cur_r.kind, rdata_r, cur_r.mask0);
        ra = cur_r.addr1[AW-1:0];
        if (cur_r.en1) begin
          state_nxt = BS_MOD1;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = BS_IDLE;
        end
      end
      BS_FETCH1: begin
        ra        = cur_r.addr1[AW-1:0];
        state_nxt = BS_MOD1;
      end
      BS_MOD1: begin
        we            = 1'b1;
        wa            = cur_r.addr1[AW-1:0];
        wd            = modify(cur_r.kind, rdata_r, cur_r.mask1);
        out_valid_nxt = 1'b1;
        state_nxt     = BS_IDLE;
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CLEAR;
      cnt_r       <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    back_ctl.pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    back_ctl.init_busy |-> !out_valid_r)
    else $error("result strobe during reset clear sweep");

  a_mod0_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_MOD0) |-> (cur_r.en0 && (cur_r.kind == K_SET || cur_r.kind == K_CLR)))
    else $error("first byte write without an enabled byte");

  a_mod1_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_MOD1) |-> (cur_r.en1 && (cur_r.kind == K_SET || cur_r.kind == K_CLR)))
    else $error("second byte write without an enabled byte");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_READ) |=> out_valid_r)
    else $error("read transaction lost its result");

endmodule
`default_nettype wire

// ----- sv/monochrome_page_framebuffer.sv -----
// Top level of the page-organized monochrome framebuffer.
// A command is taken at a clock edge with start high and busy low; each command yields
// exactly one result, shown on out_read_data for one cycle with out_valid high, and the
// receiver cannot stall it. Commands queue two deep in front of a store sequencer with
// one read and one write per cycle, which sets the pace: a pixel set/clear or a column
// write confined to its first page is written in BS_MOD0, one confined to the next page
// in BS_FETCH1 and BS_MOD1, a column byte that spans both pages in BS_MOD0 and BS_MOD1,
// a byte read is done in BS_READ, an ignored or unused command is answered from BS_IDLE,
// and clear all sweeps the store in BS_CLEAR. The result strobe is registered. After
// reset busy stays high while the store is swept to zero.
`default_nettype none
module monochrome_page_framebuffer
  import mpfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_opcode,
  input  wire logic [7:0] in_x_column,
  input  wire logic [7:0] in_y_row,
  input  wire logic [7:0] in_pattern,
  input  wire logic [3:0] in_row_count,
  input  wire logic [8:0] in_read_index,
  output logic            out_valid,
  output logic [7:0]      out_read_data
);

  logic      push;
  entry_t    push_entry;
  entry_t    head;
  q_status_t q_stat;
  back_ctl_t back_ctl;

  mpfb_front #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_front (
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_x_column  (in_x_column),
    .in_y_row     (in_y_row),
    .in_pattern   (in_pattern),
    .in_row_count (in_row_count),
    .in_read_index(in_read_index),
    .q_stat       (q_stat),
    .back_ctl     (back_ctl),
    .push         (push),
    .push_entry   (push_entry)
  );

  mpfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .back_ctl  (back_ctl),
    .q_stat    (q_stat),
    .head      (head)
  );

  mpfb_back #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head         (head),
    .back_ctl     (back_ctl),
    .out_valid    (out_valid),
    .out_read_data(out_read_data)
  );

endmodule
`default_nettype wire
